FILE: rtl/upd_pkg.sv
// ---------------------------------------------------------------------------
// upd_pkg
// Shared types and constants of the up/down pattern matcher.
// ---------------------------------------------------------------------------
package upd_pkg;

   localparam int MAX_PATTERN_DEF   = 64;
   localparam int MIN_PATTERN       = 8;
   localparam int SAMPLE_W          = 32;
   localparam int LEN_W             = 7;
   localparam int COUNT_W           = 32;
   localparam int REQ_DATA_W        = 32;
   localparam int RSP_DATA_W        = 72;
   localparam int CSR_ADDR_W        = 2;
   localparam int CSR_DATA_W        = 64;

   localparam logic [LEN_W-1:0] PATTERN_LEN_RESET = LEN_W'(MIN_PATTERN);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_PATTERN_BITS = 2'd0,
      CSR_PATTERN_LEN  = 2'd1,
      CSR_FLOAT_MODE   = 2'd2
   } csr_index_type;

   // Settings that steer the per-sample step, except the pattern itself.
   typedef struct packed {
      logic [LEN_W-1:0] pattern_len;
      logic             float_mode;
   } cfg_type;

   // One result item; match_found sits in the lowest bit.
   typedef struct packed {
      logic [COUNT_W-1:0]  match_count;
      logic [SAMPLE_W-1:0] match_start;
      logic                match_found;
   } rsp_type;

   localparam int RSP_PAD_W = RSP_DATA_W - $bits(rsp_type);

endpackage

FILE: rtl/up_down_pattern_matcher_top.sv
// ---------------------------------------------------------------------------
// up_down_pattern_matcher_top
// Order-preserving matcher on the up/down comparison stream of a text.
// ---------------------------------------------------------------------------
// Each request carries one text sample; every request yields exactly one
// response. Neighboring samples are compared (signed integer or IEEE single,
// per float_mode) to give a falling-step bit, and the response reports whether
// the last pattern_len bits equal the pattern, where that occurrence starts
// and how many occurrences the text has had so far. One request is taken every
// cycle unless a stalled response holds the pipeline; each request is held in
// the input register and its result in the response register, with the
// compare, history shift and masked equality done in the single step between
// them. A request with tlast high is answered normally and then clears the
// text state; configuration writes take effect on the next sample processed.
module up_down_pattern_matcher_top #(
   parameter int MAX_PATTERN = upd_pkg::MAX_PATTERN_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request: tdata = sample[31:0]
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [upd_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tlast,
   // response: tdata = match_found[0], match_start[32:1], match_count[64:33]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [upd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_we,
   input  logic [upd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [upd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic [MAX_PATTERN-1:0]        pattern_ff;
   logic [upd_pkg::LEN_W-1:0]     len_ff;
   logic                          float_ff;

   logic                          in_valid_ff, in_valid_in;
   logic [upd_pkg::SAMPLE_W-1:0]  in_sample_ff;
   logic                          in_last_ff;

   logic                          out_valid_ff, out_valid_in;
   upd_pkg::rsp_type              out_data_ff;

   upd_pkg::cfg_type              cfg;
   upd_pkg::rsp_type              result;
   logic                          out_free;
   logic                          advance;
   logic                          req_take;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         len_ff     <= upd_pkg::PATTERN_LEN_RESET;
         float_ff   <= 1'b0;
      end else if (csr_we) begin
         case (upd_pkg::csr_index_type'(csr_addr))
            upd_pkg::CSR_PATTERN_BITS: pattern_ff <= csr_wdata[MAX_PATTERN-1:0];
            upd_pkg::CSR_PATTERN_LEN:  len_ff     <= csr_wdata[upd_pkg::LEN_W-1:0];
            upd_pkg::CSR_FLOAT_MODE:   float_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign cfg.pattern_len = len_ff;
   assign cfg.float_mode  = float_ff;

   // Handshake: the input stage moves on whenever the response register
   // is empty or being drained.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = out_free ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_sample_ff <= req_tdata[upd_pkg::SAMPLE_W-1:0];
         in_last_ff   <= req_tlast;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   upd_track #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_track (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .sample       (in_sample_ff),
      .last_of_text (in_last_ff),
      .pattern_bits (pattern_ff),
      .cfg          (cfg),
      .result       (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{upd_pkg::RSP_PAD_W{1'b0}}, out_data_ff};

endmodule

FILE: rtl/upd_cmp.sv
// ---------------------------------------------------------------------------
// upd_cmp
// Greater-than compare of two raw samples, as signed integers or as
// IEEE single floats (any NaN operand gives 0, +0 equals -0).
// ---------------------------------------------------------------------------
module upd_cmp (
   input  logic [upd_pkg::SAMPLE_W-1:0] earlier_sample,
   input  logic [upd_pkg::SAMPLE_W-1:0] later_sample,
   input  logic                         float_mode,
   output logic                         greater
);

   localparam logic [upd_pkg::SAMPLE_W-1:0] SIGN_BIT = {1'b1, {(upd_pkg::SAMPLE_W-1){1'b0}}};

   function automatic logic is_nan(input logic [upd_pkg::SAMPLE_W-1:0] v);
      return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
   endfunction

   // Map float bits onto an unsigned key that orders like the values.
   function automatic logic [upd_pkg::SAMPLE_W-1:0] float_key(
      input logic [upd_pkg::SAMPLE_W-1:0] v);
      logic [upd_pkg::SAMPLE_W-1:0] k;
      if (v[30:0] == 31'd0) begin
         k = SIGN_BIT;
      end else if (v[31]) begin
         k = ~v;
      end else begin
         k = v ^ SIGN_BIT;
      end
      return k;
   endfunction

   logic int_gt;
   logic flt_gt;

   assign int_gt = (earlier_sample ^ SIGN_BIT) > (later_sample ^ SIGN_BIT);
   assign flt_gt = !is_nan(earlier_sample) && !is_nan(later_sample) &&
                   (float_key(earlier_sample) > float_key(later_sample));

   assign greater = float_mode ? flt_gt : int_gt;

endmodule

FILE: rtl/upd_track.sv
// ---------------------------------------------------------------------------
// upd_track
// Per-text state: previous sample, comparison history, fill level, index
// and occurrence count. Forms the result of the current sample.
// ---------------------------------------------------------------------------
module upd_track #(
   parameter int MAX_PATTERN = upd_pkg::MAX_PATTERN_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [upd_pkg::SAMPLE_W-1:0] sample,
   input  logic                         last_of_text,
   input  logic [MAX_PATTERN-1:0]       pattern_bits,
   input  upd_pkg::cfg_type             cfg,
   output upd_pkg::rsp_type             result
);

   localparam int FILL_W = $clog2(MAX_PATTERN + 1);

   logic [upd_pkg::SAMPLE_W-1:0] prev_ff, prev_in;
   logic [MAX_PATTERN-1:0]       hist_ff, hist_in;
   logic [FILL_W-1:0]            fill_ff, fill_in;
   logic [upd_pkg::SAMPLE_W-1:0] index_ff, index_in;
   logic [upd_pkg::COUNT_W-1:0]  count_ff, count_in;

   logic                         active;
   logic                         fall_bit;
   logic [MAX_PATTERN-1:0]       hist_next;
   logic [FILL_W-1:0]            fill_next;
   logic [upd_pkg::LEN_W-1:0]    eff_len;
   logic [upd_pkg::LEN_W-1:0]    shamt;
   logic [MAX_PATTERN-1:0]       aligned_pat;
   logic [MAX_PATTERN-1:0]       aligned_mask;
   logic                         hit;
   logic [upd_pkg::COUNT_W-1:0]  count_next;

   upd_cmp u_cmp (
      .earlier_sample (prev_ff),
      .later_sample   (sample),
      .float_mode     (cfg.float_mode),
      .greater        (fall_bit)
   );

   always_comb begin
      if (cfg.pattern_len < upd_pkg::LEN_W'(upd_pkg::MIN_PATTERN)) begin
         eff_len = upd_pkg::LEN_W'(upd_pkg::MIN_PATTERN);
      end else if (cfg.pattern_len > upd_pkg::LEN_W'(MAX_PATTERN)) begin
         eff_len = upd_pkg::LEN_W'(MAX_PATTERN);
      end else begin
         eff_len = cfg.pattern_len;
      end
   end

   // Line the pattern up with the newest bits at the top of the history;
   // pattern bits at or above the length fall off the top.
   assign shamt        = upd_pkg::LEN_W'(MAX_PATTERN) - eff_len;
   assign aligned_pat  = pattern_bits << shamt;
   assign aligned_mask = {MAX_PATTERN{1'b1}} << shamt;

   assign active    = (index_ff != '0) || (fill_ff != '0);
   assign hist_next = active ? {fall_bit, hist_ff[MAX_PATTERN-1:1]} : hist_ff;
   assign fill_next = (active && (fill_ff < FILL_W'(MAX_PATTERN))) ?
                      fill_ff + FILL_W'(1) : fill_ff;

   assign hit = active &&
                (upd_pkg::LEN_W'(fill_next) >= eff_len) &&
                (((hist_next ^ aligned_pat) & aligned_mask) == '0);

   assign count_next = count_ff + upd_pkg::COUNT_W'(hit);

   assign result.match_found = hit;
   assign result.match_start = hit ?
                               index_ff - upd_pkg::SAMPLE_W'(eff_len) : '0;
   assign result.match_count = count_next;

   always_comb begin
      prev_in  = prev_ff;
      hist_in  = hist_ff;
      fill_in  = fill_ff;
      index_in = index_ff;
      count_in = count_ff;
      if (step) begin
         if (last_of_text) begin
            prev_in  = '0;
            hist_in  = '0;
            fill_in  = '0;
            index_in = '0;
            count_in = '0;
         end else begin
            prev_in  = sample;
            hist_in  = hist_next;
            fill_in  = fill_next;
            index_in = index_ff + upd_pkg::SAMPLE_W'(1);
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         hist_ff  <= '0;
         fill_ff  <= '0;
         index_ff <= '0;
         count_ff <= '0;
      end else begin
         prev_ff  <= prev_in;
         hist_ff  <= hist_in;
         fill_ff  <= fill_in;
         index_ff <= index_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: rtl/upd_checker.sv
// ---------------------------------------------------------------------------
// upd_checker
// Port-level checks of the up/down pattern matcher, bound to the top level.
// ---------------------------------------------------------------------------
module upd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [upd_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // An empty response register never blocks requests.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty response register");

   // A taken request yields a valid response when the sink keeps taking.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && rsp_tready) ##1 rsp_tready |=> rsp_tvalid)
      else $error("response missing two cycles after request");

   a_no_match_start: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[32:1] == 32'd0)
      else $error("start index set without a match");

endmodule

bind up_down_pattern_matcher_top upd_checker u_checker (.*);
